>>> hdl/prq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg - priority ready queue shared definitions
// Sizes, operation and status codes, and the types passed along the cell row.
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int PRIORITY_BITS  = 5;
   localparam int THREAD_ID_BITS = 8;
   localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // contents of one queue slot
   typedef struct packed {
      logic                      valid;
      logic [THREAD_ID_BITS-1:0] thread;
      logic [PRIORITY_BITS-1:0]  prio;
   } cell_data_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                      apply;
      op_type                    op;
      logic [THREAD_ID_BITS-1:0] thread;
      logic [PRIORITY_BITS-1:0]  prio;
   } cell_cmd_type;

   localparam cell_data_type EMPTY_CELL = '{valid: 1'b0, thread: '0, prio: '0};

endpackage
`default_nettype wire

>>> hdl/prq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_req_if / prq_rsp_if - request and response channels
// Valid/ready handshake with the queue operation or result as payload.
// ----------------------------------------------------------------------------
interface prq_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        operation;
   logic [prq_pkg::THREAD_ID_BITS-1:0] thread_id;
   logic [prq_pkg::PRIORITY_BITS-1:0]  priority_req;
   logic [prq_pkg::PRIORITY_BITS-1:0]  current_priority;
   logic                              current_absent_or_idle;
   logic                              current_affinity_ok;

   modport source (output valid, operation, thread_id, priority_req, current_priority,
                   current_absent_or_idle, current_affinity_ok, input ready);
   modport sink   (input valid, operation, thread_id, priority_req, current_priority,
                   current_absent_or_idle, current_affinity_ok, output ready);
endinterface

interface prq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic [prq_pkg::THREAD_ID_BITS-1:0] out_thread_id;
   logic [prq_pkg::PRIORITY_BITS-1:0]  out_priority;
   logic                              preempt;
   logic [prq_pkg::COUNT_BITS-1:0]     occupancy;

   modport source (output valid, status, out_thread_id, out_priority, preempt, occupancy,
                   input ready);
   modport sink   (input valid, status, out_thread_id, out_priority, preempt, occupancy,
                   output ready);
endinterface
`default_nettype wire

>>> hdl/prq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prq_cell - one slot of the sorted ready queue
// Keeps, inserts, or takes its left or right neighbor's entry per command.
// ----------------------------------------------------------------------------
module prq_cell (
   input  wire                     clock,
   input  wire                     reset,
   input  prq_pkg::cell_cmd_type   cmd,
   input  prq_pkg::cell_data_type  left_data,
   input  prq_pkg::cell_data_type  right_data,
   input  wire                     ge_in,
   input  wire                     hit_in,
   output logic                    ge_out,
   output logic                    hit_out,
   output prq_pkg::cell_data_type  data_out
);
   import prq_pkg::*;

   logic                      valid_ff;
   logic [THREAD_ID_BITS-1:0] thread_ff;
   logic [PRIORITY_BITS-1:0]  prio_ff;
   cell_data_type             slot_cur;
   cell_data_type             slot_in;
   cell_data_type             new_entry;

   // current slot contents as one entry
   assign slot_cur  = '{valid: valid_ff, thread: thread_ff, prio: prio_ff};
   // this slot stays ahead of an incoming entry
   assign ge_out    = slot_cur.valid && (slot_cur.prio >= cmd.prio);
   // first matching thread at or before this slot
   assign hit_out   = hit_in || (slot_cur.valid && (slot_cur.thread == cmd.thread));
   assign new_entry = '{valid: 1'b1, thread: cmd.thread, prio: cmd.prio};
   assign data_out  = slot_cur;

   // next slot contents
   always_comb begin
      slot_in = slot_cur;
      case (cmd.op)
         OP_ENQUEUE: begin
            if (ge_out) begin
               slot_in = slot_cur;
            end else if (ge_in) begin
               slot_in = new_entry;
            end else begin
               slot_in = left_data;
            end
         end
         OP_DEQUEUE: begin
            slot_in = right_data;
         end
         OP_REMOVE: begin
            if (hit_out) begin
               slot_in = right_data;
            end
         end
         default: begin
            slot_in = slot_cur;
         end
      endcase
   end

   // valid bit under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         valid_ff <= slot_in.valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         thread_ff <= slot_in.thread;
         prio_ff   <= slot_in.prio;
      end
   end

endmodule
`default_nettype wire

>>> hdl/priority_ready_queue_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_unit - per-processor sorted ready queue
// Enqueue, dequeue, remove-by-id and preemption query on a cell row.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request: operation, thread id, priority and the
//   running thread's state for a preemption query. rsp_chan returns one
//   response per request: status, dequeued thread and priority, preempt
//   flag and the occupancy after the operation.
//   The response is registered the cycle after the request is taken. One
//   request is taken per cycle while rsp_chan takes each response; every
//   queue cell updates in the same cycle, the remove search ripples through the row.
//   Reset (synchronous) empties the queue and drops any pending response.
//   When rsp_chan stalls, the response register holds and req_chan.ready
//   falls until the response is taken; a request is accepted in the same
//   cycle that the waiting response leaves.
//   Queue full, empty and thread-not-found are reported in status and leave
//   the queue unchanged.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_unit (
   input  wire           clock,
   input  wire           reset,
   prq_req_if.sink       req_chan,
   prq_rsp_if.source     rsp_chan
);
   import prq_pkg::*;

   op_type                    op;
   logic                      accept;
   logic                      full;
   logic                      empty;
   logic [COUNT_BITS-1:0]     count_ff;
   logic [COUNT_BITS-1:0]     count_in;
   cell_cmd_type              cmd;
   cell_data_type             cells [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]      hit_chain;
   logic [QUEUE_DEPTH:0]      ge_chain;
   logic [QUEUE_DEPTH-1:0]    valid_vec;
   cell_data_type             head;

   logic                      rsp_valid_ff;
   status_type                status_ff, status_in;
   logic [THREAD_ID_BITS-1:0] otid_ff, otid_in;
   logic [PRIORITY_BITS-1:0]  oprio_ff, oprio_in;
   logic                      preempt_ff, preempt_in;
   logic [COUNT_BITS-1:0]     occ_ff;

   // handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign op             = op_type'(req_chan.operation);
   assign full           = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty          = (count_ff == '0);
   assign head           = cells[0];

   // command broadcast
   always_comb begin
      cmd.op     = op;
      cmd.thread = req_chan.thread_id;
      cmd.prio   = req_chan.priority_req;
      cmd.apply  = 1'b0;
      case (op)
         OP_ENQUEUE: cmd.apply = accept && !full;
         OP_DEQUEUE: cmd.apply = accept && !empty;
         OP_REMOVE:  cmd.apply = accept;
         default:    cmd.apply = 1'b0;
      endcase
   end

   // cell row
   assign ge_chain[0]  = 1'b1;
   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_data_type left_d;
      cell_data_type right_d;
      if (i == 0) begin : g_first
         assign left_d = EMPTY_CELL;
      end else begin : g_mid
         assign left_d = cells[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_d = EMPTY_CELL;
      end else begin : g_inner
         assign right_d = cells[i+1];
      end
      prq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .ge_in      (ge_chain[i]),
         .hit_in     (hit_chain[i]),
         .ge_out     (ge_chain[i+1]),
         .hit_out    (hit_chain[i+1]),
         .data_out   (cells[i])
      );
      assign valid_vec[i] = cells[i].valid;
   end

   // response and occupancy
   always_comb begin
      status_in  = ST_OK;
      otid_in    = '0;
      oprio_in   = '0;
      preempt_in = 1'b0;
      count_in   = count_ff;
      case (op)
         OP_ENQUEUE: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         OP_DEQUEUE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               otid_in  = head.thread;
               oprio_in = head.prio;
               count_in = count_ff - COUNT_BITS'(1);
            end
         end
         OP_REMOVE: begin
            if (hit_chain[QUEUE_DEPTH]) begin
               count_in = count_ff - COUNT_BITS'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            preempt_in = req_chan.current_absent_or_idle || !req_chan.current_affinity_ok ||
                         (head.valid && (head.prio > req_chan.current_priority));
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         otid_ff    <= otid_in;
         oprio_ff   <= oprio_in;
         preempt_ff <= preempt_in;
         occ_ff     <= count_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.out_thread_id = otid_ff;
   assign rsp_chan.out_priority  = oprio_ff;
   assign rsp_chan.preempt       = preempt_ff;
   assign rsp_chan.occupancy     = occ_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("valid cells disagree with count");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot0(valid_vec ^ (valid_vec >> 1)) && (valid_vec[0] || valid_vec == '0))
      else $error("valid cells are not a prefix");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (occ_ff == count_ff))
      else $error("response missing or occupancy mismatch");
`endif

endmodule
`default_nettype wire

>>> tb/tb_priority_ready_queue_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler_unit - ready queue scheduler testbench
// Sends enqueue, dequeue, remove and preemption query requests. A local
// sorted-queue model predicts every response, and the checker compares the
// responses in order, field by field. Both channels stall at random in parts of the run.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler_unit;
   import prq_pkg::*;

   // one predicted response
   typedef struct packed {
      status_type                status;
      logic [THREAD_ID_BITS-1:0] thread;
      logic [PRIORITY_BITS-1:0]  prio;
      logic                      preempt;
      logic [COUNT_BITS-1:0]     occupancy;
   } queue_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   prq_req_if req_bus ();
   prq_rsp_if rsp_bus ();

   priority_ready_queue_scheduler_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #2 clock = ~clock;

   // local copy of the sorted queue, slot 0 is the head
   logic [THREAD_ID_BITS-1:0] model_tid [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0]  model_prio[QUEUE_DEPTH];
   int                        model_count = 0;

   queue_reply_type expected_replies[$];

   int  fail_count    = 0;
   int  checked_count = 0;
   int  op_count[4]   = '{0, 0, 0, 0};
   int  full_hits     = 0;
   int  empty_hits    = 0;
   int  miss_hits     = 0;
   bit  stall_on      = 1'b0;
   int  send_gap_pct  = 0;
   int  ready_hold    = 0;

   // drop one slot and close the gap toward the head
   function automatic void drop_slot(input int pos);
      for (int i = pos; i + 1 < model_count; i++) begin
         model_tid[i]  = model_tid[i + 1];
         model_prio[i] = model_prio[i + 1];
      end
      model_count--;
   endfunction

   // apply one request to the local queue and return the response it gives
   function automatic queue_reply_type predict_queue_op(
      input op_type                    op,
      input logic [THREAD_ID_BITS-1:0] tid,
      input logic [PRIORITY_BITS-1:0]  prio,
      input logic [PRIORITY_BITS-1:0]  cur_prio,
      input logic                      idle,
      input logic                      aff_ok
   );
      queue_reply_type r;
      int              pos;
      r.status  = ST_OK;
      r.thread  = '0;
      r.prio    = '0;
      r.preempt = 1'b0;
      pos       = 0;
      case (op)
         OP_ENQUEUE: begin
            if (model_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
               full_hits++;
            end else begin
               // goes in ahead of the first strictly lower priority
               while (pos < model_count && model_prio[pos] >= prio) pos++;
               for (int i = model_count; i > pos; i--) begin
                  model_tid[i]  = model_tid[i - 1];
                  model_prio[i] = model_prio[i - 1];
               end
               model_tid[pos]  = tid;
               model_prio[pos] = prio;
               model_count++;
            end
         end
         OP_DEQUEUE: begin
            if (model_count == 0) begin
               r.status = ST_EMPTY;
               empty_hits++;
            end else begin
               r.thread = model_tid[0];
               r.prio   = model_prio[0];
               drop_slot(0);
            end
         end
         OP_REMOVE: begin
            // nearest the head wins when an id is queued twice
            while (pos < model_count && model_tid[pos] != tid) pos++;
            if (pos >= model_count) begin
               r.status = ST_NOT_FOUND;
               miss_hits++;
            end else begin
               drop_slot(pos);
            end
         end
         default: begin
            r.preempt = idle || !aff_ok ||
                        (model_count > 0 && model_prio[0] > cur_prio);
         end
      endcase
      r.occupancy = COUNT_BITS'(model_count);
      return r;
   endfunction

   // drive one request, wait for it to be taken, record the prediction
   task automatic push_request(
      input op_type                    op,
      input logic [THREAD_ID_BITS-1:0] tid,
      input logic [PRIORITY_BITS-1:0]  prio,
      input logic [PRIORITY_BITS-1:0]  cur_prio,
      input logic                      idle,
      input logic                      aff_ok
   );
      int gap;
      gap = 0;
      if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct)
         gap = $urandom_range(1, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid                  <= 1'b1;
      req_bus.operation              <= op;
      req_bus.thread_id              <= tid;
      req_bus.priority_req           <= prio;
      req_bus.current_priority       <= cur_prio;
      req_bus.current_absent_or_idle <= idle;
      req_bus.current_affinity_ok    <= aff_ok;
      do @(posedge clock); while (!req_bus.ready);
      expected_replies.push_back(predict_queue_op(op, tid, prio, cur_prio, idle, aff_ok));
      op_count[op]++;
   endtask

   task automatic note_mismatch(input string field, input int want, input int got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
   endtask

   // dequeue, remove and queries on an empty queue
   task automatic test_empty_queue();
      push_request(OP_DEQUEUE, 8'h00, 5'd0, 5'd0, 1'b0, 1'b1);
      push_request(OP_REMOVE, 8'h55, 5'd0, 5'd0, 1'b0, 1'b1);
      push_request(OP_QUERY, 8'h00, 5'd0, 5'd0, 1'b0, 1'b1);
      push_request(OP_QUERY, 8'h00, 5'd0, 5'd31, 1'b1, 1'b1);
      push_request(OP_QUERY, 8'h00, 5'd0, 5'd31, 1'b0, 1'b0);
   endtask

   // fill to capacity with ties, duplicate ids and extreme values
   task automatic test_sorted_insert();
      push_request(OP_ENQUEUE, 8'h10, 5'd5,  5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'hFF, 5'd31, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h00, 5'd0,  5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h11, 5'd5,  5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h12, 5'd31, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h10, 5'd17, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'hA5, 5'd1,  5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h5A, 5'd30, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h20, 5'd5,  5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h21, 5'd0,  5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h22, 5'd31, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h80, 5'd16, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h7F, 5'd15, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h01, 5'd2,  5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'hFE, 5'd29, 5'd0, 1'b0, 1'b1);
      push_request(OP_ENQUEUE, 8'h10, 5'd3,  5'd0, 1'b0, 1'b1);
      // one more than the queue holds
      push_request(OP_ENQUEUE, 8'hEE, 5'd31, 5'd0, 1'b0, 1'b1);
   endtask

   // head priority equal to and above the running thread
   task automatic test_preempt_query();
      push_request(OP_QUERY, 8'h00, 5'd0, 5'd31, 1'b0, 1'b1);
      push_request(OP_QUERY, 8'h00, 5'd0, 5'd30, 1'b0, 1'b1);
   endtask

   // remove with a duplicated id, then an id that is not queued
   task automatic test_remove_named();
      push_request(OP_REMOVE, 8'h10, 5'd0, 5'd0, 1'b0, 1'b1);
      push_request(OP_REMOVE, 8'h33, 5'd0, 5'd0, 1'b0, 1'b1);
   endtask

   // random requests; removes mostly name a queued thread
   task automatic run_random(input int n, input int enq_pct, input int deq_pct,
                             input int rem_pct);
      op_type                    op;
      logic [THREAD_ID_BITS-1:0] tid;
      logic [PRIORITY_BITS-1:0]  prio;
      logic [PRIORITY_BITS-1:0]  cur_prio;
      int                        pick;
      int                        c;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < enq_pct)                            op = OP_ENQUEUE;
         else if (pick < enq_pct + deq_pct)             op = OP_DEQUEUE;
         else if (pick < enq_pct + deq_pct + rem_pct)   op = OP_REMOVE;
         else                                           op = OP_QUERY;
         // a small id pool makes duplicates likely
         tid  = THREAD_ID_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                             : $urandom_range(0, 255));
         prio = PRIORITY_BITS'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) * 10
                                                            : $urandom_range(0, 31));
         if (op == OP_REMOVE && model_count > 0 && $urandom_range(0, 4) != 0)
            tid = model_tid[$urandom_range(0, model_count - 1)];
         cur_prio = PRIORITY_BITS'($urandom_range(0, 31));
         if (model_count > 0 && $urandom_range(0, 1) == 1) begin
            c = int'(model_prio[0]) + int'($urandom_range(0, 2)) - 1;
            if (c < 0)  c = 0;
            if (c > 31) c = 31;
            cur_prio = PRIORITY_BITS'(c);
         end
         push_request(op, tid, prio, cur_prio, $urandom_range(0, 5) == 0,
                      $urandom_range(0, 5) != 0);
      end
   endtask

   task automatic test_fill_drain();
      run_random(300, 60, 15, 10);
      run_random(300, 15, 55, 15);
   endtask

   task automatic test_mixed_traffic();
      run_random(300, 40, 30, 15);
      run_random(150, 70, 10, 5);
   endtask

   task automatic test_back_to_back(input int n);
      run_random(n, 45, 35, 10);
   endtask

   // response side: random stall bursts between ready stretches
   always @(posedge clock) begin
      if (!stall_on) begin
         rsp_bus.ready <= 1'b1;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = $urandom_range(0, 10);
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold = $urandom_range(0, 12);
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t ns: response with nothing expected, status %0d occupancy %0d",
                     $time, rsp_bus.status, rsp_bus.occupancy);
            fail_count++;
         end else begin
            want = expected_replies.pop_front();
            checked_count++;
            if (rsp_bus.status !== want.status)
               note_mismatch("status", want.status, rsp_bus.status);
            if (rsp_bus.out_thread_id !== want.thread)
               note_mismatch("out_thread_id", want.thread, rsp_bus.out_thread_id);
            if (rsp_bus.out_priority !== want.prio)
               note_mismatch("out_priority", want.prio, rsp_bus.out_priority);
            if (rsp_bus.preempt !== want.preempt)
               note_mismatch("preempt", want.preempt, rsp_bus.preempt);
            if (rsp_bus.occupancy !== want.occupancy)
               note_mismatch("occupancy", want.occupancy, rsp_bus.occupancy);
         end
      end
   end

   // run limit
   initial begin
      #3_000_000;
      $display("%0t ns: timeout, %0d responses still expected", $time,
               expected_replies.size());
      $display("priority_ready_queue_scheduler_unit test failed");
      $finish;
   end

   initial begin
      int wait_cycles;
      req_bus.valid                  <= 1'b0;
      req_bus.operation              <= OP_QUERY;
      req_bus.thread_id              <= '0;
      req_bus.priority_req           <= '0;
      req_bus.current_priority       <= '0;
      req_bus.current_absent_or_idle <= 1'b0;
      req_bus.current_affinity_ok    <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part without idling
      test_empty_queue();
      test_sorted_insert();
      test_preempt_query();
      test_remove_named();

      // random part with idling on both sides, apart from a back-to-back stretch
      stall_on     = 1'b1;
      send_gap_pct = 30;
      test_fill_drain();
      stall_on     = 1'b0;
      send_gap_pct = 0;
      test_back_to_back(150);
      stall_on     = 1'b1;
      send_gap_pct = 40;
      test_mixed_traffic();

      // closing stretch at full rate
      stall_on     = 1'b0;
      send_gap_pct = 0;
      test_back_to_back(420);
      req_bus.valid <= 1'b0;

      // let outstanding responses arrive
      wait_cycles = 0;
      while (expected_replies.size() > 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_replies.size() > 0) begin
         $display("%0t ns: %0d expected responses never arrived", $time,
                  expected_replies.size());
         fail_count++;
      end
      repeat (4) @(posedge clock);

      $display("Ran %0d enqueue, %0d dequeue, %0d remove, %0d query requests",
               op_count[OP_ENQUEUE], op_count[OP_DEQUEUE], op_count[OP_REMOVE],
               op_count[OP_QUERY]);
      $display("%0d responses checked; hit full %0d, empty %0d, not found %0d times",
               checked_count, full_hits, empty_hits, miss_hits);
      if (fail_count == 0) begin
         $display("priority_ready_queue_scheduler_unit test passed");
      end else begin
         $display("priority_ready_queue_scheduler_unit test failed");
      end
      $finish;
   end

endmodule
